/* sv/msrl_pkg.sv */
// Shared types and constants for the motor slew-rate limiter.
package msrl_pkg;

   localparam int unsigned MOTOR_W = 4;
   localparam int unsigned PWM_W   = 8;
   localparam int unsigned CFG_W   = 7;
   localparam int unsigned CSR_IDX_W = 2;

   // full-scale PWM magnitude
   localparam logic [CFG_W-1:0] PWM_FULL = 7'd127;

   // item kinds
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ZONE_EDGE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ZONE_EDGE = 2'd3;

   // configuration reset values
   localparam logic             RST_SLEW_ENABLE    = 1'b1;
   localparam logic [CFG_W-1:0] RST_SLEW_STEP      = 7'd15;
   localparam logic [CFG_W-1:0] RST_LOW_ZONE_EDGE  = 7'd10;
   localparam logic [CFG_W-1:0] RST_HIGH_ZONE_EDGE = 7'd90;

   typedef struct packed {
      logic                    kind;
      logic [MOTOR_W-1:0]      motor_index;
      logic signed [PWM_W-1:0] request_value;
      logic                    bailout;
   } req_item_type;

   typedef struct packed {
      logic [MOTOR_W-1:0]      out_motor;
      logic signed [PWM_W-1:0] pwm_value;
      logic                    bailout_active;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic             slew_enable;
      logic [CFG_W-1:0] slew_step;
      logic [CFG_W-1:0] low_zone_edge;
      logic [CFG_W-1:0] high_zone_edge;
   } cfg_type;

endpackage

/* sv/msrl_slew_unit.sv */
// Shared slew unit: zone jump, one step and clamp for one motor.
module msrl_slew_unit (
   input  msrl_pkg::cfg_type        cfg,
   input  logic signed [7:0]        now_pwm,
   input  logic signed [7:0]        req_pwm,
   output logic signed [7:0]        new_pwm
);
   import msrl_pkg::*;

   // wide enough for a jumped value plus or minus a full step
   localparam int unsigned WW = PWM_W + 2;

   logic signed [WW-1:0] now_w;
   logic signed [WW-1:0] req_w;
   logic signed [WW-1:0] low_w;
   logic signed [WW-1:0] high_w;
   logic signed [WW-1:0] step_w;
   logic signed [WW-1:0] full_w;
   logic signed [WW-1:0] base_w;
   logic signed [WW-1:0] next_w;
   logic signed [WW-1:0] lim_w;
   logic                 rising;
   logic                 far_neg;
   logic                 neg;
   logic                 dead;
   logic                 normal;

   assign now_w  = WW'(now_pwm);
   assign req_w  = WW'(req_pwm);
   assign low_w  = WW'($signed({1'b0, cfg.low_zone_edge}));
   assign high_w = WW'($signed({1'b0, cfg.high_zone_edge}));
   assign step_w = WW'($signed({1'b0, cfg.slew_step}));
   assign full_w = WW'($signed({1'b0, PWM_FULL}));

   // classify current value, tested in priority order
   assign far_neg = now_w < -high_w;
   assign neg     = now_w < -low_w;
   assign dead    = now_w <= low_w;
   assign normal  = now_w <= high_w;
   assign rising  = req_w > now_w;

   // jump across the dead zone and the flat zone first
   always_comb begin
      base_w = now_w;
      if (far_neg) begin
         base_w = rising ? -high_w : -full_w;
      end else if (neg) begin
         base_w = now_w;
      end else if (dead) begin
         base_w = rising ? low_w : -low_w;
      end else if (!normal) begin
         base_w = rising ? full_w : high_w;
      end
   end

   // single step, then clamp at the request
   assign next_w = rising ? (base_w + step_w) : (base_w - step_w);

   always_comb begin
      if (rising) begin
         lim_w = (req_w < next_w) ? req_w : next_w;
      end else begin
         lim_w = (req_w > next_w) ? req_w : next_w;
      end
   end

   always_comb begin
      if (req_pwm == now_pwm) begin
         new_pwm = now_pwm;
      end else if (!cfg.slew_enable) begin
         new_pwm = req_pwm;
      end else begin
         new_pwm = lim_w[PWM_W-1:0];
      end
   end

endmodule

/* sv/motor_slew_rate_limiter.sv */
// Top level of the motor slew-rate limiter: storage, sequencer and ports.
//
//   channel  direction  handshake        payload
//   req      in         req_valid/stall  msrl_pkg::req_item_type
//   rsp      out        rsp_valid/stall  msrl_pkg::rsp_item_type
//   csr      in         csr_valid/ready  index + 7-bit data
//
// A request item is taken whenever req_stall is low and gives no result.
// After its transfer, a tick steps one motor per cycle through the shared slew
// unit into the output register; the walk waits in every cycle in which a held
// result blocks the next load.
// req_stall stays high from an accepted tick until the final motor's result
// is loaded. Reset clears all requests and current values at once and loads
// the configuration defaults; no clearing pass is needed.
module motor_slew_rate_limiter #(
   parameter int unsigned MOTORS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  msrl_pkg::req_item_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output msrl_pkg::rsp_item_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [msrl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [msrl_pkg::CFG_W-1:0]            csr_data
);
   import msrl_pkg::*;

   localparam int unsigned IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(MOTORS - 1);
   localparam logic [MOTOR_W:0]   MOTOR_CNT = (MOTOR_W + 1)'(MOTORS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    bail_ff, bail_in;
   cfg_type                 cfg_ff, cfg_in;
   logic signed [PWM_W-1:0] cur_ff [MOTORS];
   logic signed [PWM_W-1:0] cur_in [MOTORS];
   logic signed [PWM_W-1:0] want_ff [MOTORS];
   logic signed [PWM_W-1:0] want_in [MOTORS];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_data_ff, rsp_data_in;

   logic                    req_take;
   logic                    advance;
   logic                    in_range;
   logic signed [PWM_W-1:0] req_sat;
   logic signed [PWM_W-1:0] slew_pwm;
   logic signed [PWM_W-1:0] step_pwm;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // saturate the most negative code and check the motor index
   assign req_sat  = (req_data.request_value == -8'sd128) ? -8'sd127
                                                         : req_data.request_value;
   assign in_range = {1'b0, req_data.motor_index} < MOTOR_CNT;

   // advance the walk when the output register is free or being drained
   assign advance = (state_ff == ST_WALK) && (!rsp_valid_ff || !rsp_stall);

   msrl_slew_unit u_slew (
      .cfg     (cfg_ff),
      .now_pwm (cur_ff[idx_ff]),
      .req_pwm (want_ff[idx_ff]),
      .new_pwm (slew_pwm)
   );

   assign step_pwm = bail_ff ? '0 : slew_pwm;

   // sequencer and storage update
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      bail_in      = bail_ff;
      cur_in       = cur_ff;
      want_in      = want_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_TICK) begin
                  state_in = ST_WALK;
                  idx_in   = '0;
                  bail_in  = req_data.bailout;
               end else if (in_range) begin
                  want_in[req_data.motor_index[IDX_W-1:0]] = req_sat;
               end
            end
         end
         ST_WALK: begin
            if (advance) begin
               cur_in[idx_ff] = step_pwm;
               if (bail_ff) begin
                  want_in[idx_ff] = '0;
               end
               rsp_valid_in                = 1'b1;
               rsp_data_in.out_motor       = MOTOR_W'(idx_ff);
               rsp_data_in.pwm_value       = step_pwm;
               rsp_data_in.bailout_active  = bail_ff;
               rsp_data_in.last            = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // decode configuration transfers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLEW_ENABLE:    cfg_in.slew_enable    = csr_data[0];
            CSR_SLEW_STEP:      cfg_in.slew_step      = csr_data;
            CSR_LOW_ZONE_EDGE:  cfg_in.low_zone_edge  = csr_data;
            CSR_HIGH_ZONE_EDGE: cfg_in.high_zone_edge = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_IDLE;
         idx_ff                  <= '0;
         bail_ff                 <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.slew_enable      <= RST_SLEW_ENABLE;
         cfg_ff.slew_step        <= RST_SLEW_STEP;
         cfg_ff.low_zone_edge    <= RST_LOW_ZONE_EDGE;
         cfg_ff.high_zone_edge   <= RST_HIGH_ZONE_EDGE;
         for (int i = 0; i < MOTORS; i++) begin
            cur_ff[i]  <= '0;
            want_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         bail_ff      <= bail_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         cur_ff       <= cur_in;
         want_ff      <= want_in;
      end
   end

   // hold result payload until the next load
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // a stalled result stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // a bailout tick drives every motor to zero
   a_bail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bailout_active |-> rsp_data.pwm_value == '0)
      else $error("bailout result not zero");

   // slewed value stays within the symmetric range
   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pwm_value != -8'sd128)
      else $error("pwm value out of range");

   // motor index in results stays below the motor count
   a_motor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_data.out_motor} < MOTOR_CNT)
      else $error("result motor index out of range");

endmodule
